/* src/vgmt_pkg.sv */
`default_nettype none

package vgmt_pkg;

    // Field widths of one table entry and of the result count.
    localparam int VLAN_W        = 12;
    localparam int IP_W          = 32;
    localparam int PLEN_W        = 6;
    localparam int COUNT_OUT_W   = 9;

    // Argument limits: the VLAN range applies to add and delete, the prefix range to add only.
    localparam logic [VLAN_W-1:0] VLAN_MIN_ROUTED = 12'd1;
    localparam logic [VLAN_W-1:0] VLAN_MAX_ROUTED = 12'd4094;
    localparam logic [PLEN_W-1:0] PREFIX_MIN      = 6'd1;
    localparam logic [PLEN_W-1:0] PREFIX_MAX      = 6'd32;

    typedef enum logic [1:0] {
        CMD_ADD         = 2'd0,
        CMD_DELETE      = 2'd1,
        CMD_REMOVE_VLAN = 2'd2,
        CMD_LOOKUP      = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_UPDATED     = 3'd1,
        STAT_DELETED     = 3'd2,
        STAT_NOT_FOUND   = 3'd3,
        STAT_FULL        = 3'd4,
        STAT_INVALID     = 3'd5,
        STAT_UNSUPPORTED = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // One gateway entry as held in a cell of the ring.
    typedef struct packed {
        logic [VLAN_W-1:0] vlan;
        logic [IP_W-1:0]   ip;
        logic [PLEN_W-1:0] plen;
    } t_entry;

    // Command beat.
    typedef struct packed {
        t_cmd              cmd;
        logic [VLAN_W-1:0] vlan_id;
        logic [IP_W-1:0]   ip_addr;
        logic [PLEN_W-1:0] prefix_len;
    } t_cmd_in;

    // Result beat.
    typedef struct packed {
        t_status                status;
        logic                   hit;
        logic                   vlan_active;
        logic                   announce;
        logic                   station_wanted;
        logic [COUNT_OUT_W-1:0] entry_count;
    } t_result;

    // Controls broadcast from the head controller to every ring cell.
    typedef struct packed {
        logic   shift;
        t_entry fb;
    } t_ring_ctl;

endpackage

`default_nettype wire

/* src/vgmt_cell.sv */
`default_nettype none

module vgmt_cell #(
    parameter int DEPTH = 256,
    parameter int INDEX = 0
) (
    input  wire logic                         i_clk,
    input  wire vgmt_pkg::t_ring_ctl          i_ctl,
    input  wire logic [$clog2(DEPTH+1)-1:0]   i_drops,
    input  wire vgmt_pkg::t_entry             i_next,
    output vgmt_pkg::t_entry                  o_q
);

    localparam int CW = $clog2(DEPTH + 1);

    // This cell is the write slot while the drop count equals its distance from the tail.
    localparam logic [CW-1:0] LOAD_AT = CW'(DEPTH - 1 - INDEX);

    vgmt_pkg::t_entry r_entry;
    vgmt_pkg::t_entry n_entry;

    // While the ring shifts, take the write-back beat at the write slot, else the neighbor's entry; otherwise hold.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift) begin
            if (i_drops == LOAD_AT) begin
                n_entry = i_ctl.fb;
            end else begin
                n_entry = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_q = r_entry;

endmodule

`default_nettype wire

/* src/vgmt_ctrl.sv */
`default_nettype none

module vgmt_ctrl #(
    parameter int DEPTH = 256
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_wdata,
    input  wire logic                         start,
    output logic                              busy,
    input  wire vgmt_pkg::t_cmd_in            i_cmd,
    input  wire vgmt_pkg::t_entry             i_head,
    output vgmt_pkg::t_ring_ctl               o_ring,
    output logic [$clog2(DEPTH+1)-1:0]        o_drops,
    output logic                              o_done,
    output vgmt_pkg::t_result                 o_result
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = $clog2(DEPTH);
    localparam logic [KW-1:0] LAST_K   = KW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CW = CW'(DEPTH);

    vgmt_pkg::t_state  r_state,    n_state;
    vgmt_pkg::t_cmd_in r_cmd,      n_cmd;
    logic [KW-1:0]     r_k,        n_k;
    logic [CW-1:0]     r_count,    n_count;
    logic [CW-1:0]     r_drops,    n_drops;
    logic              r_hit,      n_hit;
    logic              r_active,   n_active;
    logic              r_inserted, n_inserted;
    logic              r_enable,   n_enable;
    logic              r_done,     n_done;
    vgmt_pkg::t_result r_result,   n_result;

    logic              vlan_ok;
    logic              args_ok;
    logic              act_add;
    logic              act_del;
    logic              is_rem;
    logic              in_range;
    logic              at_tail;
    logic              m_vlan;
    logic              m_full;
    logic              drop;
    logic              ins;
    logic [CW-1:0]     new_count;
    vgmt_pkg::t_entry  new_entry;
    vgmt_pkg::t_entry  fb;
    vgmt_pkg::t_result fin;

    // Argument checks and the operation that the scan carries out.
    assign vlan_ok = (r_cmd.vlan_id >= vgmt_pkg::VLAN_MIN_ROUTED)
                  && (r_cmd.vlan_id <= vgmt_pkg::VLAN_MAX_ROUTED);
    assign args_ok = vlan_ok
                  && (r_cmd.prefix_len >= vgmt_pkg::PREFIX_MIN)
                  && (r_cmd.prefix_len <= vgmt_pkg::PREFIX_MAX);
    assign act_add = (r_cmd.cmd == vgmt_pkg::CMD_ADD) && r_enable && args_ok;
    assign act_del = (r_cmd.cmd == vgmt_pkg::CMD_DELETE) && r_enable && vlan_ok;
    assign is_rem  = (r_cmd.cmd == vgmt_pkg::CMD_REMOVE_VLAN);

    // The head cell shows slot r_k; slots below the count are live entries.
    assign in_range = (CW'(r_k) < r_count);
    assign at_tail  = (CW'(r_k) == r_count);
    assign m_vlan   = (i_head.vlan == r_cmd.vlan_id);
    assign m_full   = m_vlan && (i_head.ip == r_cmd.ip_addr);
    assign drop     = in_range && ((act_del && m_full) || (is_rem && m_vlan));
    assign ins      = at_tail && act_add && !r_hit;

    assign new_entry.vlan = r_cmd.vlan_id;
    assign new_entry.ip   = r_cmd.ip_addr;
    assign new_entry.plen = r_cmd.prefix_len;

    // Write-back beat: a new entry at the tail, an updated prefix, or the head as is.
    always_comb begin
        fb = i_head;
        if (ins) begin
            fb = new_entry;
        end else if (in_range && act_add && m_full) begin
            fb.plen = r_cmd.prefix_len;
        end
    end

    assign o_ring.shift = (r_state == vgmt_pkg::S_SCAN);
    assign o_ring.fb    = fb;
    assign o_drops      = r_drops;

    assign new_count = r_count - r_drops + CW'(r_inserted);

    // Result of the finished scan.
    always_comb begin
        fin.status         = vgmt_pkg::STAT_NOT_FOUND;
        fin.hit            = 1'b0;
        fin.vlan_active    = r_active;
        fin.announce       = r_inserted;
        fin.station_wanted = (new_count != '0);
        fin.entry_count    = vgmt_pkg::COUNT_OUT_W'(new_count);
        case (r_cmd.cmd)
            vgmt_pkg::CMD_ADD: begin
                if (!r_enable) begin
                    fin.status = vgmt_pkg::STAT_UNSUPPORTED;
                end else if (!args_ok) begin
                    fin.status = vgmt_pkg::STAT_INVALID;
                end else if (r_hit) begin
                    fin.status = vgmt_pkg::STAT_UPDATED;
                    fin.hit    = 1'b1;
                end else if (r_count >= DEPTH_CW) begin
                    fin.status = vgmt_pkg::STAT_FULL;
                end else begin
                    fin.status = vgmt_pkg::STAT_OK;
                end
            end
            vgmt_pkg::CMD_DELETE: begin
                if (!r_enable) begin
                    fin.status = vgmt_pkg::STAT_UNSUPPORTED;
                end else if (!vlan_ok) begin
                    fin.status = vgmt_pkg::STAT_INVALID;
                end else if (r_hit) begin
                    fin.status = vgmt_pkg::STAT_DELETED;
                    fin.hit    = 1'b1;
                end else begin
                    fin.status = vgmt_pkg::STAT_NOT_FOUND;
                end
            end
            vgmt_pkg::CMD_REMOVE_VLAN: begin
                if (r_drops != '0) begin
                    fin.status = vgmt_pkg::STAT_DELETED;
                end else begin
                    fin.status = vgmt_pkg::STAT_NOT_FOUND;
                end
            end
            vgmt_pkg::CMD_LOOKUP: begin
                if (r_hit) begin
                    fin.status = vgmt_pkg::STAT_OK;
                    fin.hit    = 1'b1;
                end else begin
                    fin.status = vgmt_pkg::STAT_NOT_FOUND;
                end
            end
            default: begin
                fin.status = vgmt_pkg::STAT_NOT_FOUND;
            end
        endcase
    end

    // Sequencer: one full turn of the ring per command, then a finish state that forms the result.
    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_k        = r_k;
        n_count    = r_count;
        n_drops    = r_drops;
        n_hit      = r_hit;
        n_active   = r_active;
        n_inserted = r_inserted;
        n_enable   = i_cfg_we ? i_cfg_wdata : r_enable;
        n_result   = r_result;
        n_done     = 1'b0;
        case (r_state)
            vgmt_pkg::S_IDLE: begin
                if (start) begin
                    n_cmd      = i_cmd;
                    n_k        = '0;
                    n_drops    = '0;
                    n_hit      = 1'b0;
                    n_active   = 1'b0;
                    n_inserted = 1'b0;
                    n_state    = vgmt_pkg::S_SCAN;
                end
            end
            vgmt_pkg::S_SCAN: begin
                n_hit      = r_hit || (in_range && m_full);
                n_active   = r_active || (in_range && m_vlan && !drop) || ins;
                n_inserted = r_inserted || ins;
                n_drops    = r_drops + CW'(drop);
                if (r_k == LAST_K) begin
                    n_state = vgmt_pkg::S_FINISH;
                end else begin
                    n_k = KW'(r_k + 1'b1);
                end
            end
            vgmt_pkg::S_FINISH: begin
                n_count  = new_count;
                n_result = fin;
                n_done   = 1'b1;
                n_state  = vgmt_pkg::S_IDLE;
            end
            default: begin
                n_state = vgmt_pkg::S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= vgmt_pkg::S_IDLE;
            r_count  <= '0;
            r_enable <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_enable <= n_enable;
            r_done   <= n_done;
        end
    end

    // Command, scan accumulators and result payload.
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_k        <= n_k;
        r_drops    <= n_drops;
        r_hit      <= n_hit;
        r_active   <= n_active;
        r_inserted <= n_inserted;
        r_result   <= n_result;
    end

    assign busy     = (r_state != vgmt_pkg::S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

/* src/virtual_gateway_match_table.sv */
// Virtual gateway match table.
// A command beat (add, delete, remove all of a VLAN, lookup) is taken on a
// rising edge with start high and busy low. The entries sit in a ring of
// TABLE_DEPTH cells that turns once per command past a single compare and
// edit unit at its head; deleted entries are squeezed out on the way round,
// and a new entry is written in behind the last live one.
// Each command runs a full ring turn, then a finish state that forms the result,
// which is then registered onto o_result. Busy drops in the cycle the result
// is shown, so the next command may be accepted on the edge that ends it.
// The result beat on o_result is marked by o_done, high for exactly one cycle;
// the receiver cannot stall it and must take it then.
// The user writes the enable register through i_cfg_we / i_cfg_wdata only while
// idle; the block does not enforce it. Reset clears the entry count, the enable
// and the sequencer; cell contents are kept, since only live slots are examined.
`default_nettype none

module virtual_gateway_match_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_wdata,
    input  wire logic               start,
    output logic                    busy,
    input  wire vgmt_pkg::t_cmd_in  i_cmd,
    output logic                    o_done,
    output vgmt_pkg::t_result       o_result
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    vgmt_pkg::t_entry    ring_q [TABLE_DEPTH];
    vgmt_pkg::t_ring_ctl ring_ctl;
    logic [CW-1:0]       drops;

    // Head controller: compares and edits the entry at cell zero.
    vgmt_ctrl #(
        .DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_head      (ring_q[0]),
        .o_ring      (ring_ctl),
        .o_drops     (drops),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    // Ring of cells; each hands its entry to the cell below, cell zero wraps to the top.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        vgmt_cell #(
            .DEPTH (TABLE_DEPTH),
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ring_ctl),
            .i_drops (drops),
            .i_next  (ring_q[(g + 1) % TABLE_DEPTH]),
            .o_q     (ring_q[g])
        );
    end

endmodule

`default_nettype wire

/* verif/tb_virtual_gateway_match_table.sv */
`timescale 1ns / 100ps

module tb_virtual_gateway_match_table;

    localparam int GW_DEPTH      = 256;
    localparam int CMD_LATENCY   = GW_DEPTH + 2;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 1600000;

    // One line of the directed plan: either a register write or a command beat.
    typedef struct {
        bit                 is_write;
        bit                 wr_value;
        vgmt_pkg::t_cmd_in  beat;
        bit                 typed;
        vgmt_pkg::t_result  want;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_wdata;
    logic               start;
    logic               busy;
    vgmt_pkg::t_cmd_in  i_cmd;
    logic               o_done;
    vgmt_pkg::t_result  o_result;

    // Shadow copy of the gateway table, the VLAN flags and the enable.
    logic [vgmt_pkg::VLAN_W-1:0] gw_vlan [GW_DEPTH];
    logic [vgmt_pkg::IP_W-1:0]   gw_ip   [GW_DEPTH];
    logic [vgmt_pkg::PLEN_W-1:0] gw_plen [GW_DEPTH];
    int unsigned                 gw_count;
    bit                          vlan_on [4096];
    bit                          gw_enable;

    vgmt_pkg::t_result gw_replies_due [$];
    t_row              plan [$];

    int unsigned cycle_count;
    int          n_fail;
    int          n_sent;
    int          n_full;
    int          n_announce;
    int          peak_count;
    int          gap_free_left;

    virtual_gateway_match_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d replies still due.",
                     cycle_count, gw_replies_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Linear search for an exact (vlan, address) match among live entries.
    function automatic int find_gw(input logic [vgmt_pkg::VLAN_W-1:0] v,
                                   input logic [vgmt_pkg::IP_W-1:0] a);
        for (int k = 0; k < gw_count; k++) begin
            if (gw_vlan[k] == v && gw_ip[k] == a) return k;
        end
        return -1;
    endfunction

    // Move the last entry into the freed slot, then refresh that VLAN's flag.
    function automatic void drop_gw(input int slot);
        logic [vgmt_pkg::VLAN_W-1:0] v;
        bit                          still;
        v = gw_vlan[slot];
        still = 1'b0;
        gw_count = gw_count - 1;
        gw_vlan[slot] = gw_vlan[gw_count];
        gw_ip[slot]   = gw_ip[gw_count];
        gw_plen[slot] = gw_plen[gw_count];
        for (int k = 0; k < gw_count; k++) begin
            if (gw_vlan[k] == v) still = 1'b1;
        end
        vlan_on[v] = still;
    endfunction

    // Apply one command to the shadow table and return the reply it must give.
    function automatic vgmt_pkg::t_result apply_gw_command(input vgmt_pkg::t_cmd_in c);
        vgmt_pkg::t_result r;
        int                pos;
        int                k;
        bit                any;
        r = '0;
        r.status = vgmt_pkg::STAT_OK;
        case (c.cmd)
            vgmt_pkg::CMD_ADD: begin
                pos = find_gw(c.vlan_id, c.ip_addr);
                if (!gw_enable) begin
                    r.status = vgmt_pkg::STAT_UNSUPPORTED;
                end else if (c.vlan_id < vgmt_pkg::VLAN_MIN_ROUTED ||
                             c.vlan_id > vgmt_pkg::VLAN_MAX_ROUTED ||
                             c.prefix_len < vgmt_pkg::PREFIX_MIN ||
                             c.prefix_len > vgmt_pkg::PREFIX_MAX) begin
                    r.status = vgmt_pkg::STAT_INVALID;
                end else if (pos >= 0) begin
                    gw_plen[pos] = c.prefix_len;
                    r.status = vgmt_pkg::STAT_UPDATED;
                    r.hit = 1'b1;
                end else if (gw_count >= GW_DEPTH) begin
                    r.status = vgmt_pkg::STAT_FULL;
                end else begin
                    gw_vlan[gw_count] = c.vlan_id;
                    gw_ip[gw_count]   = c.ip_addr;
                    gw_plen[gw_count] = c.prefix_len;
                    gw_count = gw_count + 1;
                    vlan_on[c.vlan_id] = 1'b1;
                    r.announce = 1'b1;
                end
            end
            vgmt_pkg::CMD_DELETE: begin
                pos = find_gw(c.vlan_id, c.ip_addr);
                if (!gw_enable) begin
                    r.status = vgmt_pkg::STAT_UNSUPPORTED;
                end else if (c.vlan_id < vgmt_pkg::VLAN_MIN_ROUTED ||
                             c.vlan_id > vgmt_pkg::VLAN_MAX_ROUTED) begin
                    r.status = vgmt_pkg::STAT_INVALID;
                end else if (pos >= 0) begin
                    drop_gw(pos);
                    r.status = vgmt_pkg::STAT_DELETED;
                    r.hit = 1'b1;
                end else begin
                    r.status = vgmt_pkg::STAT_NOT_FOUND;
                end
            end
            vgmt_pkg::CMD_REMOVE_VLAN: begin
                k = 0;
                any = 1'b0;
                while (k < gw_count) begin
                    if (gw_vlan[k] == c.vlan_id) begin
                        drop_gw(k);
                        any = 1'b1;
                    end else begin
                        k++;
                    end
                end
                r.status = any ? vgmt_pkg::STAT_DELETED : vgmt_pkg::STAT_NOT_FOUND;
            end
            default: begin
                if (find_gw(c.vlan_id, c.ip_addr) >= 0) begin
                    r.hit = 1'b1;
                end else begin
                    r.status = vgmt_pkg::STAT_NOT_FOUND;
                end
            end
        endcase
        r.vlan_active    = (c.vlan_id != '0) && vlan_on[c.vlan_id];
        r.station_wanted = (gw_count != 0);
        r.entry_count    = gw_count[vgmt_pkg::COUNT_OUT_W-1:0];
        return r;
    endfunction

    // Compare a reply beat field by field against the oldest expectation.
    task automatic check_reply(input vgmt_pkg::t_result want, input vgmt_pkg::t_result got);
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            n_fail++;
        end
        if (got.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, got.hit);
            n_fail++;
        end
        if (got.vlan_active !== want.vlan_active) begin
            $error("vlan_active: expected %0d, got %0d", want.vlan_active, got.vlan_active);
            n_fail++;
        end
        if (got.announce !== want.announce) begin
            $error("announce: expected %0d, got %0d", want.announce, got.announce);
            n_fail++;
        end
        if (got.station_wanted !== want.station_wanted) begin
            $error("station_wanted: expected %0d, got %0d",
                   want.station_wanted, got.station_wanted);
            n_fail++;
        end
        if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
            n_fail++;
        end
    endtask

    // Reply monitor: every strobed beat must match the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (gw_replies_due.size() == 0) begin
                $error("reply beat with no command outstanding: status %0d", o_result.status);
                n_fail++;
            end else begin
                check_reply(gw_replies_due.pop_front(), o_result);
            end
        end
    end

    // Directed plan builders.
    function automatic void plan_cmd(input vgmt_pkg::t_cmd c,
                                     input logic [vgmt_pkg::VLAN_W-1:0] v,
                                     input logic [vgmt_pkg::IP_W-1:0] a,
                                     input logic [vgmt_pkg::PLEN_W-1:0] p);
        t_row r;
        r = '{default: '0};
        r.beat.cmd = c;
        r.beat.vlan_id = v;
        r.beat.ip_addr = a;
        r.beat.prefix_len = p;
        plan.push_back(r);
    endfunction

    function automatic void plan_chk(input vgmt_pkg::t_cmd c,
                                     input logic [vgmt_pkg::VLAN_W-1:0] v,
                                     input logic [vgmt_pkg::IP_W-1:0] a,
                                     input logic [vgmt_pkg::PLEN_W-1:0] p,
                                     input vgmt_pkg::t_status s, input bit h, input bit act,
                                     input bit ann, input int n);
        t_row r;
        r = '{default: '0};
        r.beat.cmd = c;
        r.beat.vlan_id = v;
        r.beat.ip_addr = a;
        r.beat.prefix_len = p;
        r.typed = 1'b1;
        r.want.status = s;
        r.want.hit = h;
        r.want.vlan_active = act;
        r.want.announce = ann;
        r.want.station_wanted = (n != 0);
        r.want.entry_count = n[vgmt_pkg::COUNT_OUT_W-1:0];
        plan.push_back(r);
    endfunction

    function automatic void plan_cfg(input bit value);
        t_row r;
        r = '{default: '0};
        r.is_write = 1'b1;
        r.wr_value = value;
        plan.push_back(r);
    endfunction

    // Random command beat; a fill beat mostly adds fresh addresses to grow the table.
    function automatic vgmt_pkg::t_cmd_in make_beat(input bit fill, input int remove_pct);
        vgmt_pkg::t_cmd_in b;
        int                pick;
        b = '0;
        if (fill && $urandom_range(0, 9) != 0) begin
            b.cmd = vgmt_pkg::CMD_ADD;
            b.vlan_id = 12'($urandom_range(1, 4));
            b.ip_addr = $urandom;
            b.prefix_len = 6'($urandom_range(1, 32));
            return b;
        end
        pick = $urandom_range(0, 99);
        if (pick < remove_pct) begin
            b.cmd = vgmt_pkg::CMD_REMOVE_VLAN;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 40) b.cmd = vgmt_pkg::CMD_ADD;
            else if (pick < 65) b.cmd = vgmt_pkg::CMD_DELETE;
            else b.cmd = vgmt_pkg::CMD_LOOKUP;
        end
        // A small pool of VLANs and addresses so that matches are frequent.
        case ($urandom_range(0, 9))
            0, 1, 2: b.vlan_id = 12'd1;
            3, 4:    b.vlan_id = 12'd2;
            5, 6:    b.vlan_id = 12'd3;
            7:       b.vlan_id = vgmt_pkg::VLAN_MAX_ROUTED;
            8:       b.vlan_id = 12'd7;
            default: b.vlan_id = 12'($urandom_range(0, 4095));
        endcase
        case ($urandom_range(0, 9))
            0:       b.ip_addr = 32'h0000_0000;
            1:       b.ip_addr = 32'hFFFF_FFFF;
            2:       b.ip_addr = 32'h0A00_0001;
            3:       b.ip_addr = 32'h0A00_0002;
            4:       b.ip_addr = 32'hC0A8_0101;
            5:       b.ip_addr = 32'hC0A8_01FE;
            6:       b.ip_addr = 32'hAC10_0001;
            7:       b.ip_addr = 32'h7F00_0001;
            default: b.ip_addr = $urandom;
        endcase
        if ($urandom_range(0, 9) == 0) b.prefix_len = 6'($urandom_range(0, 63));
        else b.prefix_len = 6'($urandom_range(1, 32));
        return b;
    endfunction

    // Present one command beat, wait for it to be taken, then idle for a drawn gap.
    // Entered and left at a falling edge; start stays high when no gap is drawn.
    task automatic send_cmd(input vgmt_pkg::t_cmd_in beat, input bit typed,
                            input vgmt_pkg::t_result want);
        vgmt_pkg::t_result model_r;
        int                gap;
        start <= 1'b1;
        i_cmd <= beat;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        model_r = apply_gw_command(beat);
        gw_replies_due.push_back(typed ? want : model_r);
        n_sent++;
        if (model_r.status == vgmt_pkg::STAT_FULL) n_full++;
        if (model_r.announce) n_announce++;
        if (gw_count > peak_count) peak_count = gw_count;
        if (gap_free_left > 0) begin
            gap = 0;
            gap_free_left--;
        end else if ($urandom_range(0, 19) == 0) begin
            gap = 0;
            gap_free_left = $urandom_range(10, 40);
        end else begin
            gap = $urandom_range(0, 13);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Hold off until every reply due has arrived and the block has settled.
    task automatic wait_idle();
        start <= 1'b0;
        while (gw_replies_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_enable(input bit value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        gw_enable = value;
    endtask

    // Main sequence: reset, directed plan, then random phases over both enables.
    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        cycle_count = 0;
        n_fail = 0;
        n_sent = 0;
        n_full = 0;
        n_announce = 0;
        peak_count = 0;
        gap_free_left = 0;
        gw_count = 0;
        gw_enable = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Disabled block right after reset.
        plan_chk(vgmt_pkg::CMD_LOOKUP, 12'd1, 32'h0, 6'd8,
                 vgmt_pkg::STAT_NOT_FOUND, 0, 0, 0, 0);
        plan_chk(vgmt_pkg::CMD_ADD, 12'd1, 32'h0, 6'd8,
                 vgmt_pkg::STAT_UNSUPPORTED, 0, 0, 0, 0);
        plan_chk(vgmt_pkg::CMD_DELETE, 12'd1, 32'h0, 6'd8,
                 vgmt_pkg::STAT_UNSUPPORTED, 0, 0, 0, 0);
        plan_chk(vgmt_pkg::CMD_REMOVE_VLAN, 12'd5, 32'h0, 6'd0,
                 vgmt_pkg::STAT_NOT_FOUND, 0, 0, 0, 0);
        plan_cfg(1'b1);
        // Bad add arguments at both ends of the VLAN and prefix ranges.
        plan_chk(vgmt_pkg::CMD_ADD, 12'd0, 32'h0, 6'd8, vgmt_pkg::STAT_INVALID, 0, 0, 0, 0);
        plan_chk(vgmt_pkg::CMD_ADD, 12'd4095, 32'h0, 6'd8, vgmt_pkg::STAT_INVALID, 0, 0, 0, 0);
        plan_chk(vgmt_pkg::CMD_ADD, 12'd1, 32'h0, 6'd0, vgmt_pkg::STAT_INVALID, 0, 0, 0, 0);
        plan_chk(vgmt_pkg::CMD_ADD, 12'd1, 32'h0, 6'd33, vgmt_pkg::STAT_INVALID, 0, 0, 0, 0);
        plan_chk(vgmt_pkg::CMD_ADD, 12'd1, 32'h0, 6'd63, vgmt_pkg::STAT_INVALID, 0, 0, 0, 0);
        // New entries at the extremes, then an update of an existing one.
        plan_chk(vgmt_pkg::CMD_ADD, 12'd1, 32'h0, 6'd1, vgmt_pkg::STAT_OK, 0, 1, 1, 1);
        plan_chk(vgmt_pkg::CMD_ADD, 12'd4094, 32'hFFFF_FFFF, 6'd32,
                 vgmt_pkg::STAT_OK, 0, 1, 1, 2);
        plan_chk(vgmt_pkg::CMD_ADD, 12'd1, 32'h0, 6'd24, vgmt_pkg::STAT_UPDATED, 1, 1, 0, 2);
        plan_chk(vgmt_pkg::CMD_LOOKUP, 12'd1, 32'h0, 6'd0, vgmt_pkg::STAT_OK, 1, 1, 0, 2);
        plan_chk(vgmt_pkg::CMD_LOOKUP, 12'd0, 32'h0, 6'd0,
                 vgmt_pkg::STAT_NOT_FOUND, 0, 0, 0, 2);
        // Delete argument checks and a miss, then an add, a delete and VLAN removals.
        plan_chk(vgmt_pkg::CMD_DELETE, 12'd0, 32'h0, 6'd0,
                 vgmt_pkg::STAT_INVALID, 0, 0, 0, 2);
        plan_chk(vgmt_pkg::CMD_DELETE, 12'd4095, 32'hFFFF_FFFF, 6'd0,
                 vgmt_pkg::STAT_INVALID, 0, 0, 0, 2);
        plan_chk(vgmt_pkg::CMD_DELETE, 12'd1, 32'h5, 6'd63,
                 vgmt_pkg::STAT_NOT_FOUND, 0, 1, 0, 2);
        plan_cmd(vgmt_pkg::CMD_ADD, 12'd1, 32'h1234_5678, 6'd16);
        plan_cmd(vgmt_pkg::CMD_DELETE, 12'd1, 32'h0, 6'd0);
        plan_cmd(vgmt_pkg::CMD_REMOVE_VLAN, 12'd1, 32'h0, 6'd0);
        plan_chk(vgmt_pkg::CMD_REMOVE_VLAN, 12'd0, 32'h0, 6'd0,
                 vgmt_pkg::STAT_NOT_FOUND, 0, 0, 0, 1);
        plan_chk(vgmt_pkg::CMD_REMOVE_VLAN, 12'd4095, 32'h0, 6'd0,
                 vgmt_pkg::STAT_NOT_FOUND, 0, 0, 0, 1);
        // Add and delete are refused while disabled; lookups and VLAN removal keep working.
        plan_cfg(1'b0);
        plan_chk(vgmt_pkg::CMD_DELETE, 12'd4094, 32'hFFFF_FFFF, 6'd0,
                 vgmt_pkg::STAT_UNSUPPORTED, 0, 1, 0, 1);
        plan_chk(vgmt_pkg::CMD_ADD, 12'd2, 32'h1, 6'd8,
                 vgmt_pkg::STAT_UNSUPPORTED, 0, 0, 0, 1);
        plan_cmd(vgmt_pkg::CMD_LOOKUP, 12'd4094, 32'hFFFF_FFFF, 6'd0);
        plan_chk(vgmt_pkg::CMD_REMOVE_VLAN, 12'd4094, 32'h0, 6'd0,
                 vgmt_pkg::STAT_DELETED, 0, 0, 0, 0);
        plan_cfg(1'b1);

        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                wait_idle();
                write_enable(plan[i].wr_value);
            end else begin
                send_cmd(plan[i].beat, plan[i].typed, plan[i].want);
            end
        end

        // Enabled traffic on a small working set, with occasional full drains.
        for (int n = 0; n < 500; n++) begin
            if ($urandom_range(0, 49) == 0) wait_idle();
            send_cmd(make_beat(1'b0, 8), 1'b0, '0);
        end
        wait_idle();
        write_enable(1'b0);
        for (int n = 0; n < 120; n++) send_cmd(make_beat(1'b0, 10), 1'b0, '0);
        wait_idle();
        write_enable(1'b1);
        // Push adds past the table's depth, then churn and strip VLANs from it.
        for (int n = 0; n < 340; n++) send_cmd(make_beat(1'b1, 2), 1'b0, '0);
        for (int n = 0; n < 100; n++) send_cmd(make_beat(1'b0, 20), 1'b0, '0);
        wait_idle();
        write_enable(1'b0);
        for (int n = 0; n < 40; n++) send_cmd(make_beat(1'b0, 15), 1'b0, '0);
        wait_idle();
        write_enable(1'b1);
        for (int n = 0; n < 300; n++) begin
            if ($urandom_range(0, 49) == 0) wait_idle();
            send_cmd(make_beat(1'b0, 8), 1'b0, '0);
        end

        wait_idle();
        repeat (CMD_LATENCY + 8) @(negedge i_clk);
        $display("Ran %0d commands across both enable settings; peak occupancy %0d of %0d.",
                 n_sent, peak_count, GW_DEPTH);
        $display("Full-table refusals: %0d, new entries announced: %0d, mismatches: %0d.",
                 n_full, n_announce, n_fail);
        if (n_fail == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* sim.f */
src/vgmt_pkg.sv
src/vgmt_cell.sv
src/vgmt_ctrl.sv
src/virtual_gateway_match_table.sv
verif/tb_virtual_gateway_match_table.sv
